// File: rtl/core/pid_tustin_antiwindup_slew_defines.svh
// Assertion macros used by the top-level file to check its own logic.
`ifndef PID_TUSTIN_ANTIWINDUP_SLEW_DEFINES_SVH
`define PID_TUSTIN_ANTIWINDUP_SLEW_DEFINES_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define PTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define PTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/pts_pkg.sv
package pts_pkg;

   // 1 ms expressed as an unsigned Q0.32 period
   localparam logic [31:0] MS_PERIOD     = 32'd4294967;
   localparam logic [31:0] TICK_RATE_RST = 32'd170000000;

   // quotient bits produced by the shared restoring divider
   localparam int unsigned PERIOD_STEPS = 32;
   localparam int unsigned DERIV_STEPS  = 48;
   localparam int unsigned CntW         = $clog2(DERIV_STEPS);

   // register indexes of the write port
   typedef enum logic [2:0] {
      REG_PROP_GAIN    = 3'd0,
      REG_INTEG_GAIN   = 3'd1,
      REG_DERIV_GAIN   = 3'd2,
      REG_SLEW_LIMIT   = 3'd3,
      REG_OUTPUT_LIMIT = 3'd4,
      REG_TICK_RATE    = 3'd5
   } csr_idx_type;

   // datapath commands issued by the controller
   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_DIV_STEP,
      OP_PERIOD,
      OP_MUL_K,
      OP_MUL_P,
      OP_MUL_I,
      OP_MUL_M,
      OP_DINIT,
      OP_MUL_S,
      OP_SUM,
      OP_CLAMP,
      OP_SLEW,
      OP_TMUL_K,
      OP_TMUL_A,
      OP_TFIN,
      OP_TSKIP,
      OP_OUT
   } dp_op_type;

   // datapath status seen by the controller
   typedef struct packed {
      logic is_track;
      logic trk_skip;
      logic d_cap;
   } dp_status_type;

endpackage

// File: rtl/core/pid_tustin_antiwindup_slew.sv
// PID step in Q16.16 with a trapezoid integrator, conditional integration,
// output clamp and slew limit. An update transaction runs through one shared
// restoring divider that produces one quotient bit a cycle: 32 bits for the
// period and 48 bits for the derivative (none when the derivative saturates),
// plus steps through one 32x33 multiplier. A tracking transaction runs two
// multiplier steps and an integrator update, or neither when it is ignored.
// The input is ready again as soon as the result is loaded into the output
// register; a result still waiting there holds the next one back. The user
// must write configuration through csr_we/csr_addr/csr_wdata only while the
// block is idle; the block itself does not enforce this.
module pid_tustin_antiwindup_slew
   import pts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_addr,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic signed [31:0] req_error_in,
   input  logic [31:0]        req_elapsed_ticks,
   input  logic signed [31:0] req_correction,
   input  logic signed [31:0] req_track_gain,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive,
   output logic               rsp_clamped,
   output logic               rsp_slewed,
   output logic               rsp_integ_held
);

`include "pid_tustin_antiwindup_slew_defines.svh"

   dp_op_type     op;
   dp_status_type status;

   // sequencer
   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .op        (op)
   );

   // arithmetic and state
   pts_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .status            (status),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_cmd           (req_cmd),
      .req_error_in      (req_error_in),
      .req_elapsed_ticks (req_elapsed_ticks),
      .req_correction    (req_correction),
      .req_track_gain    (req_track_gain),
      .rsp_drive         (rsp_drive),
      .rsp_clamped       (rsp_clamped),
      .rsp_slewed        (rsp_slewed),
      .rsp_integ_held    (rsp_integ_held)
   );

   // checks
   `PTS_ASSERT_NOW(a_accept_cmd, clock, reset, req_valid && req_ready, op == OP_ACCEPT, "accept without capture")
   `PTS_ASSERT_NEXT(a_busy_after, clock, reset, req_valid && req_ready, !req_ready, "ready right after accept")
   `PTS_ASSERT_NEXT(a_out_valid, clock, reset, op == OP_OUT, rsp_valid, "result loaded but not valid")

endmodule

// File: rtl/core/pts_ctrl.sv
module pts_ctrl
   import pts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_op_type     op
);

   typedef enum logic [4:0] {
      S_IDLE, S_BRANCH, S_TDIV, S_PERIOD, S_MUL_K, S_MUL_P, S_MUL_I, S_MUL_M,
      S_DINIT, S_DDIV, S_MUL_S, S_SUM, S_CLAMP, S_SLEW,
      S_TMUL_K, S_TMUL_A, S_TFIN, S_TSKIP, S_RESP
   } state_type;

   state_type       state_ff;
   logic [CntW-1:0] cnt_ff;
   logic            rsp_valid_ff;
   logic            out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      case (state_ff)
         S_IDLE:   op = req_valid ? OP_ACCEPT : OP_NONE;
         S_TDIV:   op = OP_DIV_STEP;
         S_PERIOD: op = OP_PERIOD;
         S_MUL_K:  op = OP_MUL_K;
         S_MUL_P:  op = OP_MUL_P;
         S_MUL_I:  op = OP_MUL_I;
         S_MUL_M:  op = OP_MUL_M;
         S_DINIT:  op = OP_DINIT;
         S_DDIV:   op = status.d_cap ? OP_NONE : OP_DIV_STEP;
         S_MUL_S:  op = OP_MUL_S;
         S_SUM:    op = OP_SUM;
         S_CLAMP:  op = OP_CLAMP;
         S_SLEW:   op = OP_SLEW;
         S_TMUL_K: op = OP_TMUL_K;
         S_TMUL_A: op = OP_TMUL_A;
         S_TFIN:   op = OP_TFIN;
         S_TSKIP:  op = OP_TSKIP;
         S_RESP:   op = out_free ? OP_OUT : OP_NONE;
         default:  op = OP_NONE;
      endcase
   end

   // sequencer and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_BRANCH;
               end
            end
            S_BRANCH: begin
               cnt_ff <= '0;
               if (status.is_track) begin
                  state_ff <= status.trk_skip ? S_TSKIP : S_TMUL_K;
               end else begin
                  state_ff <= S_TDIV;
               end
            end
            S_TDIV: begin
               cnt_ff <= cnt_ff + CntW'(1);
               if (cnt_ff == CntW'(PERIOD_STEPS - 1)) begin
                  state_ff <= S_PERIOD;
               end
            end
            S_PERIOD: state_ff <= S_MUL_K;
            S_MUL_K:  state_ff <= S_MUL_P;
            S_MUL_P:  state_ff <= S_MUL_I;
            S_MUL_I:  state_ff <= S_MUL_M;
            S_MUL_M:  state_ff <= S_DINIT;
            S_DINIT: begin
               cnt_ff   <= '0;
               state_ff <= S_DDIV;
            end
            S_DDIV: begin
               cnt_ff <= cnt_ff + CntW'(1);
               if (status.d_cap || cnt_ff == CntW'(DERIV_STEPS - 1)) begin
                  state_ff <= S_MUL_S;
               end
            end
            S_MUL_S:  state_ff <= S_SUM;
            S_SUM:    state_ff <= S_CLAMP;
            S_CLAMP:  state_ff <= S_SLEW;
            S_SLEW:   state_ff <= S_RESP;
            S_TMUL_K: state_ff <= S_TMUL_A;
            S_TMUL_A: state_ff <= S_TFIN;
            S_TFIN:   state_ff <= S_RESP;
            S_TSKIP:  state_ff <= S_RESP;
            S_RESP: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/core/pts_dp.sv
module pts_dp
   import pts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_op_type          op,
   output dp_status_type      status,
   input  logic               csr_we,
   input  logic [2:0]         csr_addr,
   input  logic [31:0]        csr_wdata,
   input  logic               req_cmd,
   input  logic signed [31:0] req_error_in,
   input  logic [31:0]        req_elapsed_ticks,
   input  logic signed [31:0] req_correction,
   input  logic signed [31:0] req_track_gain,
   output logic signed [31:0] rsp_drive,
   output logic               rsp_clamped,
   output logic               rsp_slewed,
   output logic               rsp_integ_held
);

   // signed value from magnitude and sign
   function automatic logic signed [49:0] with_sign(logic [48:0] mag, logic neg);
      logic signed [49:0] v;
      v = $signed({1'b0, mag});
      return neg ? -v : v;
   endfunction

   // clamp to +-lim
   function automatic logic signed [31:0] clamp_val(logic signed [51:0] v,
                                                    logic [30:0] lim);
      logic signed [51:0] lp;
      logic signed [51:0] ln;
      lp = $signed({21'b0, lim});
      ln = -lp;
      if (v > lp) return lp[31:0];
      if (v < ln) return ln[31:0];
      return v[31:0];
   endfunction

   // configuration
   logic [31:0] prop_ff, igain_ff, dgain_ff, rate_ff;
   logic [30:0] slew_ff, lim_ff;

   // controller state
   logic signed [31:0] integ_ff, lerr_ff, lout_ff;
   logic [31:0]        lper_ff;

   // captured transaction
   logic               cmd_ff;
   logic signed [31:0] err_ff, corr_ff, tgain_ff;

   // work registers
   logic [31:0]        ts_ff, div_ff, rem_ff, k_ff;
   logic [47:0]        shf_ff, quo_ff;
   logic               ms_ff, dcap_ff;
   logic [64:0]        prod_ff;
   logic signed [49:0] p_ff, d_ff;
   logic signed [31:0] inext_ff, dc_ff;
   logic signed [51:0] sum_ff;
   logic [30:0]        step_ff;
   logic               held_ff, clamped_ff;
   logic signed [31:0] res_drive_ff;
   logic               res_clamped_ff, res_slewed_ff, res_held_ff;

   // combinational
   logic [31:0]        rate_eff, err_mag, corr_mag, dif_mag, ts_nx;
   logic [32:0]        s_e, s_mag, dif, dif_abs;
   logic [31:0]        mul_a;
   logic [32:0]        mul_b;
   logic [64:0]        prod_in;
   logic [32:0]        rem_sh, rem_sub;
   logic               q_bit;
   logic [31:0]        rem_nx;
   logic signed [49:0] iterm, tterm;
   logic signed [51:0] lim52, d_sum, t_sum;
   logic               outside, held;
   logic signed [32:0] dv, stepv;
   logic signed [31:0] drv;
   logic               slw;

   assign rate_eff = (rate_ff == '0) ? 32'd1 : rate_ff;
   assign err_mag  = err_ff[31] ? (~err_ff + 32'd1) : err_ff;
   assign corr_mag = corr_ff[31] ? (~corr_ff + 32'd1) : corr_ff;
   assign s_e      = {err_ff[31], err_ff} + {lerr_ff[31], lerr_ff};
   assign s_mag    = s_e[32] ? (~s_e + 33'd1) : s_e;
   assign dif      = {err_ff[31], err_ff} - {lerr_ff[31], lerr_ff};
   assign dif_abs  = dif[32] ? (~dif + 33'd1) : dif;
   assign dif_mag  = dif_abs[31:0];
   assign ts_nx    = ms_ff ? MS_PERIOD : quo_ff[31:0];
   assign lim52    = $signed({21'b0, lim_ff});

   assign status.is_track = cmd_ff;
   assign status.trk_skip = tgain_ff[31] || (tgain_ff == '0) || (lper_ff == '0);
   assign status.d_cap    = dcap_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op)
         OP_MUL_K: begin
            mul_a = igain_ff;
            mul_b = {1'b0, ts_ff};
         end
         OP_MUL_P: begin
            mul_a = prop_ff;
            mul_b = {1'b0, err_mag};
         end
         OP_MUL_I: begin
            mul_a = k_ff;
            mul_b = s_mag;
         end
         OP_MUL_M: begin
            mul_a = dgain_ff;
            mul_b = {1'b0, dif_mag};
         end
         OP_MUL_S: begin
            mul_a = {1'b0, slew_ff};
            mul_b = {1'b0, ts_ff};
         end
         OP_TMUL_K: begin
            mul_a = tgain_ff;
            mul_b = {1'b0, lper_ff};
         end
         OP_TMUL_A: begin
            mul_a = prod_ff[63:32];
            mul_b = {1'b0, corr_mag};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod_in = mul_a * mul_b;

   // one restoring divide step
   assign rem_sh  = {rem_ff, shf_ff[47]};
   assign rem_sub = rem_sh - {1'b0, div_ff};
   assign q_bit   = (rem_sh >= {1'b0, div_ff});
   assign rem_nx  = q_bit ? rem_sub[31:0] : rem_sh[31:0];

   // integrator terms
   assign iterm = with_sign({1'b0, prod_ff[64:17]}, s_e[32]);
   assign d_sum = 52'(integ_ff) + 52'(iterm);
   assign tterm = with_sign({1'b0, prod_ff[63:16]}, corr_ff[31]);
   assign t_sum = 52'(integ_ff) + 52'(tterm);

   // anti-windup decision
   assign outside = (sum_ff > lim52) || (sum_ff < -lim52);
   assign held    = outside && ((!err_ff[31] && err_ff != '0 && sum_ff > 0) ||
                                (err_ff[31] && sum_ff < 0));

   // slew limiter
   assign dv    = 33'(dc_ff) - 33'(lout_ff);
   assign stepv = $signed({2'b00, step_ff});
   always_comb begin
      drv = dc_ff;
      slw = 1'b0;
      if (slew_ff != '0) begin
         if (dv > stepv) begin
            drv = lout_ff + $signed({1'b0, step_ff});
            slw = 1'b1;
         end else if (-dv > stepv) begin
            drv = lout_ff - $signed({1'b0, step_ff});
            slw = 1'b1;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_ff  <= '0;
         igain_ff <= '0;
         dgain_ff <= '0;
         slew_ff  <= '0;
         lim_ff   <= '0;
         rate_ff  <= TICK_RATE_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_PROP_GAIN:    prop_ff  <= csr_wdata;
            REG_INTEG_GAIN:   igain_ff <= csr_wdata;
            REG_DERIV_GAIN:   dgain_ff <= csr_wdata;
            REG_SLEW_LIMIT:   slew_ff  <= csr_wdata[30:0];
            REG_OUTPUT_LIMIT: lim_ff   <= csr_wdata[30:0];
            REG_TICK_RATE:    rate_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         lerr_ff  <= '0;
         lout_ff  <= '0;
         lper_ff  <= '0;
      end else begin
         case (op)
            OP_PERIOD: lper_ff <= ts_nx;
            OP_CLAMP: begin
               if (!held) begin
                  integ_ff <= inext_ff;
               end
            end
            OP_SLEW: begin
               lout_ff <= drv;
               lerr_ff <= err_ff;
            end
            OP_TFIN: integ_ff <= clamp_val(t_sum, lim_ff);
            default: ;
         endcase
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (op)
         OP_ACCEPT: begin
            cmd_ff   <= req_cmd;
            err_ff   <= req_error_in;
            corr_ff  <= req_correction;
            tgain_ff <= req_track_gain;
            div_ff   <= rate_eff;
            rem_ff   <= req_elapsed_ticks;
            shf_ff   <= '0;
            quo_ff   <= '0;
            ms_ff    <= (req_elapsed_ticks == '0) ||
                        ({req_elapsed_ticks, 1'b0} > {1'b0, rate_eff});
         end
         OP_DIV_STEP: begin
            rem_ff <= rem_nx;
            shf_ff <= {shf_ff[46:0], 1'b0};
            quo_ff <= {quo_ff[46:0], q_bit};
         end
         OP_PERIOD: ts_ff <= ts_nx;
         OP_MUL_P:  k_ff <= prod_ff[63:32];
         OP_MUL_I:  p_ff <= with_sign({1'b0, prod_ff[63:16]}, err_ff[31]);
         OP_MUL_M:  inext_ff <= clamp_val(d_sum, lim_ff);
         OP_DINIT: begin
            div_ff  <= ts_ff;
            rem_ff  <= prod_ff[63:32];
            shf_ff  <= {prod_ff[31:0], 16'b0};
            quo_ff  <= '0;
            dcap_ff <= (prod_ff[63:32] >= ts_ff);
         end
         OP_MUL_S: begin
            d_ff <= with_sign(dcap_ff ? 49'h1_0000_0000_0000 : {1'b0, quo_ff}, dif[32]);
         end
         OP_SUM: begin
            sum_ff  <= 52'(p_ff) + 52'(inext_ff) + 52'(d_ff);
            step_ff <= prod_ff[62:32];
         end
         OP_CLAMP: begin
            held_ff    <= held;
            clamped_ff <= outside;
            dc_ff      <= clamp_val(sum_ff, lim_ff);
         end
         OP_SLEW: begin
            res_drive_ff   <= drv;
            res_clamped_ff <= clamped_ff;
            res_slewed_ff  <= slw;
            res_held_ff    <= held_ff;
         end
         OP_TFIN, OP_TSKIP: begin
            res_drive_ff   <= lout_ff;
            res_clamped_ff <= 1'b0;
            res_slewed_ff  <= 1'b0;
            res_held_ff    <= (op == OP_TSKIP);
         end
         OP_OUT: begin
            rsp_drive      <= res_drive_ff;
            rsp_clamped    <= res_clamped_ff;
            rsp_slewed     <= res_slewed_ff;
            rsp_integ_held <= res_held_ff;
         end
         default: ;
      endcase
   end

endmodule
